FILE: hdl/lc3_instruction_execute_unit_defines.svh
// Assertion macros shared by the execute unit.
`ifndef LC3_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
// Asserts that a condition implies another on the same edge.
`define LC3_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication failed");
// Asserts that a condition implies another on the next edge.
`define LC3_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");
`endif

FILE: hdl/lc3_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LC-3 execute unit package
// Shared types, codes and constants for the front end, queue and back end.
// ---------------------------------------------------------------------------
package lc3_pkg;
	localparam int MEM_ADDR_BITS_DEF = 16;
	localparam logic [15:0] START_PC_RESET = 16'h3000;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_STEP  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_TRAP = 2'd1,
		ST_HALT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_BR = 4'h0, OP_ADD = 4'h1, OP_LD = 4'h2, OP_ST = 4'h3,
		OP_JSR = 4'h4, OP_AND = 4'h5, OP_LDR = 4'h6, OP_STR = 4'h7,
		OP_RTI = 4'h8, OP_NOT = 4'h9, OP_LDI = 4'hA, OP_STI = 4'hB,
		OP_JMP = 4'hC, OP_RES = 4'hD, OP_LEA = 4'hE, OP_TRAP = 4'hF
	} opcode_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_FETCH, BK_DECODE, BK_READ1, BK_READ2, BK_STORE,
		BK_MEMRD, BK_DONE
	} bk_state_t;

	// Item as classified by the front end.
	typedef struct packed {
		func_t       func;
		logic [15:0] address;
		logic [15:0] data;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] pc_after;
		logic [2:0]  cond_flags;
		logic [15:0] executed_word;
		logic        dest_written;
		logic [2:0]  dest_index;
		logic [15:0] dest_value;
		logic        store_done;
		logic [15:0] store_address;
		logic [15:0] store_data;
		logic [15:0] read_data;
	} result_t;

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic [15:0] m;
		m = (16'd1 << bits) - 16'd1;
		return v[bits-1] ? (v | ~m) : (v & m);
	endfunction

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v == 16'd0) return 3'd2;
		if (v[15]) return 3'd4;
		return 3'd1;
	endfunction
endpackage

FILE: hdl/lc3_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data.
// ---------------------------------------------------------------------------
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: hdl/lc3_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LC-3 front end
// Accepts items and queues them for the back end.
// ---------------------------------------------------------------------------
module lc3_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    func,
	input  logic [15:0]   address,
	input  logic [15:0]   data,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          cmd_valid,
	output lc3_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import lc3_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	cmd_t         queue_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;
	logic          push;

	assign in_stall  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= '{func: func_t'(func), address: address, data: data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(cmd_take);
		end
	end
endmodule

FILE: hdl/lc3_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LC-3 back end
// Runs one item at a time against the memory and registers.
// ---------------------------------------------------------------------------
module lc3_back #(
	parameter int MEM_ADDR_BITS = lc3_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  lc3_pkg::cmd_t   cmd,
	output logic            cmd_take,
	input  logic            cfg_valid,
	input  logic [15:0]     cfg_data,
	output logic            res_valid,
	output lc3_pkg::result_t res,
	input  logic            res_stall
);
	import lc3_pkg::*;

	localparam int AW = MEM_ADDR_BITS;

	bk_state_t   state_q, state_d;
	logic [15:0] gpr_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic        halted_q;
	cmd_t        cmd_q;
	logic [15:0] word_q, t_q;
	result_t     res_q;
	logic        res_valid_q;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata, mem_rdata;

	lc3_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	// The fetched word comes straight from the RAM in DECODE and from word_q later.
	logic [15:0] word;
	logic [3:0]  op;
	logic [2:0]  dr, sr1;
	logic [15:0] pc1, pc_off9, base6, b_op, alu;
	assign word    = (state_q == BK_DECODE) ? mem_rdata : word_q;
	assign op      = word[15:12];
	assign dr      = word[11:9];
	assign sr1     = word[8:6];
	assign pc1     = pc_q + 16'd1;
	assign pc_off9 = pc1 + sext(word, 9);
	assign base6   = gpr_q[sr1] + sext(word, 6);
	assign b_op    = word[5] ? sext(word, 5) : gpr_q[word[2:0]];
	assign alu     = (op == OP_ADD) ? gpr_q[sr1] + b_op : gpr_q[sr1] & b_op;

	// Output register frees when empty or taken.
	logic out_free;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	logic    finish;
	result_t fin;
	logic    wr_gpr;
	logic [2:0]  wr_idx;
	logic [15:0] wr_val, pc_new;
	logic        cc_upd, halt_set;

	always_comb begin
		state_d   = state_q;
		cmd_take  = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = AW'(pc_q);
		mem_wdata = cmd_q.data;
		finish    = 1'b0;
		fin       = '0;
		wr_gpr    = 1'b0;
		wr_idx    = dr;
		wr_val    = '0;
		pc_new    = pc_q;
		cc_upd    = 1'b0;
		halt_set  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					state_d  = BK_FETCH;
				end
			end
			BK_FETCH: begin
				unique case (cmd_q.func)
					FUNC_WRITE: begin
						mem_we   = 1'b1;
						mem_addr = AW'(cmd_q.address);
						state_d  = BK_DONE;
					end
					FUNC_READ: begin
						mem_addr = AW'(cmd_q.address);
						state_d  = BK_MEMRD;
					end
					FUNC_STEP: begin
						mem_addr = AW'(pc_q);
						state_d  = halted_q ? BK_DONE : BK_DECODE;
					end
					default: state_d = BK_DONE;
				endcase
			end
			BK_MEMRD: begin
				state_d = BK_DONE;
			end
			BK_DECODE: begin
				// Fetched word is on the RAM output here; issue the first operand read.
				unique case (op)
					OP_LD, OP_LDI, OP_STI: begin
						mem_addr = AW'(pc_off9);
						state_d  = BK_READ1;
					end
					OP_LDR: begin
						mem_addr = AW'(base6);
						state_d  = BK_READ1;
					end
					default: state_d = BK_STORE;
				endcase
			end
			BK_READ1: begin
				if (op == OP_LDI) begin
					mem_addr = AW'(mem_rdata);
					state_d  = BK_READ2;
				end else begin
					state_d = BK_STORE;
				end
			end
			BK_READ2: state_d = BK_STORE;
			BK_STORE: begin
				// Execute stage: t_q holds the last memory word read.
				if (out_free) begin
					finish = 1'b1;
					state_d = BK_IDLE;
					pc_new = pc1;
					fin.executed_word = word_q;
					unique case (op)
						OP_BR: if ((dr & cc_q) != 3'd0) pc_new = pc_off9;
						OP_ADD, OP_AND: begin wr_gpr = 1'b1; wr_val = alu; end
						OP_NOT: begin wr_gpr = 1'b1; wr_val = ~gpr_q[sr1]; end
						OP_LD, OP_LDR, OP_LDI: begin wr_gpr = 1'b1; wr_val = t_q; end
						OP_LEA: begin wr_gpr = 1'b1; wr_val = pc_off9; end
						OP_ST, OP_STI, OP_STR: begin
							fin.store_done = 1'b1;
							fin.store_address = (op == OP_ST) ? 16'(AW'(pc_off9)) :
								(op == OP_STI) ? 16'(AW'(t_q)) : 16'(AW'(base6));
							fin.store_data = gpr_q[dr];
							mem_we    = 1'b1;
							mem_addr  = AW'(fin.store_address);
							mem_wdata = gpr_q[dr];
						end
						OP_JMP: pc_new = gpr_q[sr1];
						OP_JSR: begin
							pc_new = word_q[11] ? pc1 + sext(word_q, 11) : gpr_q[sr1];
							wr_gpr = 1'b1; wr_idx = 3'd7; wr_val = pc1;
						end
						OP_TRAP: begin
							fin.status = ST_TRAP;
							fin.read_data = {8'd0, word_q[7:0]};
						end
						default: halt_set = 1'b1;
					endcase
					cc_upd = wr_gpr && (op != OP_JSR);
					fin.dest_written = wr_gpr;
					fin.dest_index   = wr_gpr ? wr_idx : 3'd0;
					fin.dest_value   = wr_val;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					finish = 1'b1;
					state_d = BK_IDLE;
					if (cmd_q.func == FUNC_READ) fin.read_data = t_q;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		fin.pc_after   = pc_new;
		fin.cond_flags = cc_upd ? cc_of(wr_val) : cc_q;
		if (halted_q || halt_set) fin.status = ST_HALT;
	end

	// The fetched word is on the RAM output in DECODE; capture it on leaving DECODE.
	always_ff @(posedge clk) begin
		if (cmd_take) cmd_q <= cmd;
		if (state_q == BK_DECODE || state_q == BK_READ1 || state_q == BK_READ2 ||
			state_q == BK_MEMRD) begin
			t_q <= mem_rdata;
		end
		if (state_q == BK_DECODE) word_q <= mem_rdata;
		if (finish) res_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pc_q        <= START_PC_RESET;
			cc_q        <= 3'd2;
			halted_q    <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) gpr_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (finish) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			if (cfg_valid) pc_q <= cfg_data;
			else if (finish && state_q == BK_STORE) pc_q <= pc_new;
			if (finish && cc_upd) cc_q <= cc_of(wr_val);
			if (finish && halt_set) halted_q <= 1'b1;
			if (finish && wr_gpr) gpr_q[wr_idx] <= wr_val;
		end
	end
endmodule

FILE: hdl/lc3_instruction_execute_unit.sv
`timescale 1ns / 1ps
// LC-3 execute unit: a 16-bit LC-3 core with private word memory. Each item
// writes a memory word, executes the instruction at the PC, or reads a word;
// one result item comes back per input item in order. A two-entry queue
// decouples the accepting front end from the back end, so new items are taken
// while the back end works or a result waits. The back end uses one
// single-port RAM with registered read. The back end works on one item at
// a time: a write item is written, a read item waits for its read, and an
// instruction goes through fetch, decode, one operand read for LD, LDR and
// STI and a second dependent read for LDI, then execute. Memory
// is not cleared by reset; reading a word that was never written returns
// unspecified data. Writing start_pc also loads the program counter and must
// happen while idle.
// ---------------------------------------------------------------------------
// LC-3 instruction execute unit, top level
// Front end, queue and back end around one word memory.
// ---------------------------------------------------------------------------
module lc3_instruction_execute_unit #(
	parameter int MEM_ADDR_BITS = lc3_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] pc_after,
	output logic [2:0]  cond_flags,
	output logic [15:0] executed_word,
	output logic        dest_written,
	output logic [2:0]  dest_index,
	output logic [15:0] dest_value,
	output logic        store_done,
	output logic [15:0] store_address,
	output logic [15:0] store_data,
	output logic [15:0] read_data
);
	import lc3_pkg::*;
	`include "lc3_instruction_execute_unit_defines.svh"

	cmd_t    cmd;
	logic    cmd_valid, cmd_take;
	result_t res;

	assign cfg_ready = 1'b1;

	lc3_front u_front (
		.clk(clk), .arst_n(arst_n), .func(func), .address(address), .data(data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take)
	);

	lc3_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.res_valid(out_valid), .res(res), .res_stall(out_stall)
	);

	assign status        = res.status;
	assign pc_after      = res.pc_after;
	assign cond_flags    = res.cond_flags;
	assign executed_word = res.executed_word;
	assign dest_written  = res.dest_written;
	assign dest_index    = res.dest_index;
	assign dest_value    = res.dest_value;
	assign store_done    = res.store_done;
	assign store_address = res.store_address;
	assign store_data    = res.store_data;
	assign read_data     = res.read_data;

	`LC3_ASSERT_IMPLY(a_take_needs_item, clk, arst_n, cmd_take, cmd_valid)
	`LC3_ASSERT_IMPLY(a_flags_onehot, clk, arst_n, out_valid, $onehot(cond_flags))
	`LC3_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid)
endmodule

FILE: dv/tb_lc3_instruction_execute_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LC-3 instruction execute unit testbench
// Loads small programs and data into the core's memory, executes them one
// instruction at a time and reads words back. Every result item is checked
// against a predictor kept inside this bench, under random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_lc3_instruction_execute_unit;
	import lc3_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = 2'd0;
	logic [15:0] address = 16'd0;
	logic [15:0] data = 16'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] pc_after;
	logic [2:0]  cond_flags;
	logic [15:0] executed_word;
	logic        dest_written;
	logic [2:0]  dest_index;
	logic [15:0] dest_value;
	logic        store_done;
	logic [15:0] store_address;
	logic [15:0] store_data;
	logic [15:0] read_data;

	lc3_instruction_execute_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .address(address), .data(data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pc_after(pc_after), .cond_flags(cond_flags),
		.executed_word(executed_word), .dest_written(dest_written),
		.dest_index(dest_index), .dest_value(dest_value),
		.store_done(store_done), .store_address(store_address),
		.store_data(store_data), .read_data(read_data)
	);

	always #4 clk = ~clk;

	// Items waiting to be offered, and the results they are predicted to give.
	cmd_t    pending_items[$];
	result_t expected_results[$];
	int      queued_items = 0;

	// Shadow of the core's architectural state, advanced as items are queued.
	// Items are processed strictly in order, so predicting at queue time
	// gives the same answers as predicting at acceptance.
	logic [15:0] mem_img[int];
	int          written_addrs[$];
	logic [15:0] gpr[8];
	logic [15:0] shadow_pc;
	logic [2:0]  shadow_cc;
	logic        shadow_halted;

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;

	// The long receiver hold-off runs in its own process; the stimulus
	// process only toggles a request.
	logic hold_request = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_cycles = 0;

	function automatic logic [15:0] signext(input logic [15:0] v, input int n);
		return 16'($signed(v << (16 - n)) >>> (16 - n));
	endfunction

	function automatic logic [2:0] flags_for(input logic [15:0] v);
		if (v == 16'd0)
			return 3'd2;
		return v[15] ? 3'd4 : 3'd1;
	endfunction

	function automatic logic mem_known(input logic [15:0] a);
		return mem_img.exists(a);
	endfunction

	// Advances the shadow state by one item and returns the result it gives.
	task automatic compute_result(input cmd_t c, output result_t r);
		logic [15:0] w, npc, t, v;
		logic [2:0]  dr, sr1;
		logic        wr_reg;
		r = '0;
		wr_reg = 1'b0;
		v = 16'd0;
		case (c.func)
			FUNC_WRITE: begin
				if (!mem_known(c.address))
					written_addrs.push_back(c.address);
				mem_img[c.address] = c.data;
			end
			FUNC_READ: r.read_data = mem_img[c.address];
			FUNC_STEP: if (!shadow_halted) begin
				w = mem_img[shadow_pc];
				r.executed_word = w;
				npc = shadow_pc + 16'd1;
				dr = w[11:9];
				sr1 = w[8:6];
				case (opcode_t'(w[15:12]))
					OP_BR: if (w[11:9] & shadow_cc)
						npc = npc + signext(w, 9);
					OP_ADD, OP_AND: begin
						t = w[5] ? signext(w, 5) : gpr[w[2:0]];
						v = (w[15:12] == OP_ADD) ? gpr[sr1] + t : gpr[sr1] & t;
						wr_reg = 1'b1;
					end
					OP_NOT: begin
						v = ~gpr[sr1];
						wr_reg = 1'b1;
					end
					OP_LD: begin
						v = mem_img[npc + signext(w, 9)];
						wr_reg = 1'b1;
					end
					OP_LDI: begin
						v = mem_img[mem_img[npc + signext(w, 9)]];
						wr_reg = 1'b1;
					end
					OP_LDR: begin
						v = mem_img[gpr[sr1] + signext(w, 6)];
						wr_reg = 1'b1;
					end
					OP_LEA: begin
						v = npc + signext(w, 9);
						wr_reg = 1'b1;
					end
					OP_ST, OP_STI, OP_STR: begin
						if (w[15:12] == OP_ST)
							r.store_address = npc + signext(w, 9);
						else if (w[15:12] == OP_STI)
							r.store_address = mem_img[npc + signext(w, 9)];
						else
							r.store_address = gpr[sr1] + signext(w, 6);
						r.store_data = gpr[dr];
						r.store_done = 1'b1;
					end
					OP_JMP: npc = gpr[sr1];
					OP_JSR: begin
						// R7 is reported as written but the flags stay put.
						// JSRR through R7 must use the old R7, so read it first.
						t = npc;
						npc = w[11] ? npc + signext(w, 11) : gpr[sr1];
						gpr[7] = t;
						r.dest_written = 1'b1;
						r.dest_index = 3'd7;
						r.dest_value = t;
					end
					OP_TRAP: begin
						r.status = ST_TRAP;
						r.read_data = {8'd0, w[7:0]};
					end
					default: shadow_halted = 1'b1;
				endcase
				if (wr_reg) begin
					gpr[dr] = v;
					shadow_cc = flags_for(v);
					r.dest_written = 1'b1;
					r.dest_index = dr;
					r.dest_value = v;
				end
				if (r.store_done) begin
					if (!mem_known(r.store_address))
						written_addrs.push_back(r.store_address);
					mem_img[r.store_address] = r.store_data;
				end
				shadow_pc = npc;
			end
			default: ;
		endcase
		if (shadow_halted)
			r.status = ST_HALT;
		r.pc_after = shadow_pc;
		r.cond_flags = shadow_cc;
	endtask

	task automatic queue_item(input func_t f, input logic [15:0] a, input logic [15:0] d);
		cmd_t c;
		result_t r;
		c.func = f;
		c.address = a;
		c.data = d;
		compute_result(c, r);
		pending_items.push_back(c);
		expected_results.push_back(r);
		queued_items++;
	endtask

	// Operands are loaded with random words before they are ever read.
	task automatic fill_if_unknown(input logic [15:0] a);
		if (!mem_known(a))
			queue_item(FUNC_WRITE, a, 16'($urandom));
	endtask

	// Loads whatever the instruction at the PC will read from memory.
	task automatic fill_operands(input logic [15:0] w);
		logic [15:0] npc, ptr;
		npc = shadow_pc + 16'd1;
		case (opcode_t'(w[15:12]))
			OP_LD, OP_STI: fill_if_unknown(npc + signext(w, 9));
			OP_LDI: begin
				ptr = npc + signext(w, 9);
				fill_if_unknown(ptr);
				fill_if_unknown(mem_img[ptr]);
			end
			OP_LDR: fill_if_unknown(gpr[w[8:6]] + signext(w, 6));
			default: ;
		endcase
	endtask

	// Places an instruction at the PC, loads whatever it will read and runs it.
	task automatic run_instruction(input logic [15:0] w);
		queue_item(FUNC_WRITE, shadow_pc, w);
		fill_operands(w);
		queue_item(FUNC_STEP, 16'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] random_instruction();
		opcode_t ops[14] = '{OP_BR, OP_ADD, OP_LD, OP_ST, OP_JSR, OP_AND, OP_LDR,
			OP_STR, OP_NOT, OP_LDI, OP_STI, OP_JMP, OP_LEA, OP_TRAP};
		return {ops[$urandom_range(13)], 12'($urandom)};
	endfunction

	function automatic logic runnable(input logic [15:0] w);
		return w[15:12] != OP_RTI && w[15:12] != OP_RES;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		// Results all arrive before the core can go quiet; give it time.
		repeat (20) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [15:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		shadow_pc = v;
	endtask

	// Driver: a new item goes out only when the last one was taken.
	always @(posedge clk)
		in_taken <= in_valid && !in_stall;

	always @(negedge clk) begin : driver
		cmd_t c;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				c = pending_items.pop_front();
				func <= c.func;
				address <= c.address;
				data <= c.data;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls at random, and for a long stretch when asked.
	always @(negedge clk) begin
		if (hold_request != hold_seen) begin
			hold_seen <= hold_request;
			hold_cycles <= 300;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
		out_stall <= (hold_cycles > 1) || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Monitor: every result item taken is compared with the oldest prediction.
	always @(posedge clk) begin : monitor
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result item with none expected, actual pc %h",
					$time, pc_after);
			end else begin
				e = expected_results.pop_front();
				check_field("status", 16'(e.status), 16'(status));
				check_field("pc_after", e.pc_after, pc_after);
				check_field("cond_flags", 16'(e.cond_flags), 16'(cond_flags));
				check_field("executed_word", e.executed_word, executed_word);
				check_field("dest_written", 16'(e.dest_written), 16'(dest_written));
				check_field("dest_index", 16'(e.dest_index), 16'(dest_index));
				check_field("dest_value", e.dest_value, dest_value);
				check_field("store_done", 16'(e.store_done), 16'(store_done));
				check_field("store_address", e.store_address, store_address);
				check_field("store_data", e.store_data, store_data);
				check_field("read_data", e.read_data, read_data);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int sel;
		int phase_base;
		int pct_send[4] = '{0, 83, 0, 35};
		int pct_recv[4] = '{0, 0, 83, 35};
		logic [15:0] pc_values[4] = '{16'h3000, 16'h0000, 16'hFFFF, 16'h3000};
		for (int i = 0; i < 8; i++)
			gpr[i] = 16'd0;
		shadow_pc = START_PC_RESET;
		shadow_cc = 3'd2;
		shadow_halted = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: memory extremes, the unused func code, every non-halting operation but LDI.
		queue_item(FUNC_WRITE, 16'h0000, 16'hFFFF);
		queue_item(FUNC_WRITE, 16'hFFFF, 16'h0000);
		queue_item(FUNC_READ, 16'h0000, 16'h0000);
		queue_item(FUNC_READ, 16'hFFFF, 16'hFFFF);
		queue_item(FUNC_NONE, 16'hFFFF, 16'hFFFF);
		run_instruction(16'h1230);  // ADD R1,R0,#-16
		run_instruction(16'h146F);  // ADD R2,R1,#15
		run_instruction(16'h1642);  // ADD R3,R1,R2
		run_instruction(16'h58FF);  // AND R4,R3,#-1
		run_instruction(16'h5A01);  // AND R5,R0,R1 gives zero
		run_instruction(16'h9C7F);  // NOT R6,R1
		run_instruction(16'hE100);  // LEA R0,#-256
		run_instruction(16'h22FF);  // LD
		run_instruction(16'h25FF);  // LD of its own instruction word
		run_instruction(16'h679F);  // LDR
		run_instruction(16'h3205);  // ST
		run_instruction(16'hB400);  // STI
		run_instruction(16'h7620);  // STR with the most negative offset
		run_instruction(16'h00FF);  // BR with no condition bits
		run_instruction(16'h0E02);  // BRnzp always taken
		run_instruction(16'hC140);  // JMP R5
		run_instruction(16'h4C00);  // JSR backward
		run_instruction(16'h41C0);  // JSRR through R7 itself
		run_instruction(16'hF025);  // TRAP

		// Random phases, each under its own idling pattern and start PC.
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_start_pc(ph == 3 ? 16'($urandom) : pc_values[ph]);
			send_idle_pct = pct_send[ph];
			recv_stall_pct = pct_recv[ph];
			if (ph == 0)
				hold_request = ~hold_request;
			phase_base = queued_items;
			while (queued_items - phase_base < RANDOM_ITEMS / 4) begin
				sel = $urandom_range(99);
				if (sel < 60) begin
					if (mem_known(shadow_pc) && runnable(mem_img[shadow_pc])
							&& $urandom_range(1)) begin
						fill_operands(mem_img[shadow_pc]);
						queue_item(FUNC_STEP, 16'($urandom), 16'($urandom));
					end else begin
						run_instruction(random_instruction());
					end
				end else if (sel < 80) begin
					queue_item(FUNC_WRITE, 16'($urandom), 16'($urandom));
				end else if (sel < 95) begin
					queue_item(FUNC_READ,
						16'(written_addrs[$urandom_range(written_addrs.size() - 1)]),
						16'($urandom));
				end else begin
					queue_item(FUNC_NONE, 16'($urandom), 16'($urandom));
				end
			end
		end

		// Last of all, an illegal opcode halts the core for good.
		run_instruction($urandom_range(1) ? 16'h8000 : {4'hD, 12'($urandom)});
		queue_item(FUNC_STEP, 16'h0000, 16'h0000);
		queue_item(FUNC_WRITE, 16'h1234, 16'hBEEF);
		queue_item(FUNC_READ, 16'h1234, 16'h0000);
		queue_item(FUNC_NONE, 16'h0000, 16'h0000);

		wait_idle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
